// ===== design/isfb_pkg.sv =====
package isfb_pkg;

    // Default configuration of the block.
    localparam int SENSOR_SLOTS_DEF     = 3;
    localparam int OFFSET_FRAC_BITS_DEF = 4;

    // Field and register widths.
    localparam int AXIS_W      = 16;
    localparam int AXES        = 6;
    localparam int OFF_FIELD_W = 21;
    localparam int OFF_REG_W   = 63;
    localparam int CFG_INDEX_W = 3;
    localparam int COUNT_W     = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_SENSOR_COUNT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_OFF_0  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GYRO_OFF_0   = 3'd2;

    // Frame layout.
    localparam logic [7:0] SYNC_BYTE_0   = 8'hAA;
    localparam logic [7:0] SYNC_BYTE_1   = 8'h55;
    localparam logic [7:0] FRAME_VERSION = 8'h01;
    localparam int         SIZE_BASE     = 8;
    localparam int         SIZE_PER_SLOT = 12;

    // Byte positions within the frame layout of one reading.
    localparam logic [4:0] POS_FIRST_AXIS = 5'd12;
    localparam logic [4:0] POS_LAST_AXIS  = 5'd23;
    localparam logic [4:0] POS_CHECKSUM   = 5'd24;

    // One corrected reading, ready for the serializer.
    typedef struct packed {
        logic                        header;
        logic                        last;
        logic [7:0]                  size_byte;
        logic [31:0]                 elapsed_us;
        logic [31:0]                 frame_cnt;
        logic [AXES-1:0][AXIS_W-1:0] axis;
    } isfb_item_t;

endpackage

// ===== design/imu_sample_frame_builder.sv =====
// Channel   Direction  Transfer moves
// s_*       in         one six-axis reading with its read-ok flag and elapsed time
// m_*       out        one byte of the framed stream, tlast on the checksum byte
// cfg_*     in         one configuration register write, no handshake
//
// Each reading becomes 12 to 25 output bytes, one per cycle while m_tready is
// high: 12 axis bytes, plus 12 for a header and one for a checksum. Input and
// output overlap through a one-reading holding stage. rst_n clears the frame
// state and all configuration registers to their defaults at once; no clearing
// pass is needed. A stall on m_tready holds the current byte and, once the
// holding stage is full, s_tready.
module imu_sample_frame_builder #(
    parameter int SENSOR_SLOTS     = isfb_pkg::SENSOR_SLOTS_DEF,
    parameter int OFFSET_FRAC_BITS = isfb_pkg::OFFSET_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // s_tdata, lowest bits first: elapsed_us[31:0], accel_x, accel_y, accel_z,
    // gyro_x, gyro_y, gyro_z (16 bits each).
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [127:0]                        s_tdata,
    // s_tuser: read_ok.
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata: out_byte.
    output logic [7:0]                          m_tdata,
    // m_tlast: frame_end.
    output logic                                m_tlast,
    input  logic                                cfg_we,
    input  logic [isfb_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [isfb_pkg::OFF_REG_W-1:0]      cfg_wdata
);

    localparam int FW = isfb_pkg::OFF_FIELD_W;
    localparam int AW = isfb_pkg::AXIS_W;

    // Configuration registers. Offsets exist only for the slots this instance has.
    logic [isfb_pkg::COUNT_W-1:0]   sensor_count_reg;
    logic [isfb_pkg::OFF_REG_W-1:0] accel_off_reg [SENSOR_SLOTS];
    logic [isfb_pkg::OFF_REG_W-1:0] gyro_off_reg  [SENSOR_SLOTS];

    // Frame sequencing state, advanced when a reading is accepted.
    logic [isfb_pkg::COUNT_W-1:0]   slot_reg, slot_next;
    logic [31:0]                    frame_cnt_reg, frame_cnt_next;

    // Holding stage between the input transfer and the lanes.
    logic                                 pend_valid_reg, pend_valid_next;
    logic                                 pend_ok_reg;
    logic [isfb_pkg::COUNT_W-1:0]         pend_slot_reg;
    logic                                 pend_header_reg;
    logic                                 pend_last_reg;
    logic [7:0]                           pend_size_reg;
    logic [31:0]                          pend_elapsed_reg;
    logic [31:0]                          pend_frame_cnt_reg;
    logic [isfb_pkg::AXES-1:0][AW-1:0]    pend_raw_reg;

    logic                         s_xfer;
    logic                         item_take;
    logic [isfb_pkg::COUNT_W-1:0] count_eff;
    logic                         is_header;
    logic                         is_last;
    logic [isfb_pkg::OFF_REG_W-1:0] accel_sel;
    logic [isfb_pkg::OFF_REG_W-1:0] gyro_sel;
    logic [isfb_pkg::AXES-1:0][AW-1:0] corrected;
    isfb_pkg::isfb_item_t         item;

    assign s_xfer   = s_tvalid && s_tready;
    assign s_tready = !pend_valid_reg || item_take;

    // A count of zero means one sensor; a count above the slot total saturates.
    always_comb
    begin
        if (sensor_count_reg == '0)
            count_eff = isfb_pkg::COUNT_W'(1);
        else if (32'(sensor_count_reg) > SENSOR_SLOTS)
            count_eff = isfb_pkg::COUNT_W'(SENSOR_SLOTS);
        else
            count_eff = sensor_count_reg;
    end

    // The reading that reaches the active count closes the frame. This also
    // covers a count lowered below the current slot in the middle of a frame.
    assign is_header = (slot_reg == '0);
    assign is_last   = ({1'b0, slot_reg} + 3'd1) >= {1'b0, count_eff};

    always_comb
    begin
        slot_next      = slot_reg;
        frame_cnt_next = frame_cnt_reg;
        if (s_xfer)
        begin
            slot_next = is_last ? '0 : slot_reg + isfb_pkg::COUNT_W'(1);
            if (is_header)
                frame_cnt_next = frame_cnt_reg + 32'd1;
        end
    end

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (item_take)
            pend_valid_next = 1'b0;
        if (s_xfer)
            pend_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sensor_count_reg <= isfb_pkg::COUNT_W'(1);
            for (int k = 0; k < SENSOR_SLOTS; k++)
            begin
                accel_off_reg[k] <= '0;
                gyro_off_reg[k]  <= '0;
            end
            slot_reg       <= '0;
            frame_cnt_reg  <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == isfb_pkg::REG_SENSOR_COUNT))
                sensor_count_reg <= cfg_wdata[isfb_pkg::COUNT_W-1:0];
            // Slot k owns the accel and gyro registers at two consecutive indexes.
            for (int k = 0; k < SENSOR_SLOTS; k++)
            begin
                if (cfg_we && (cfg_index == isfb_pkg::REG_ACCEL_OFF_0
                                           + isfb_pkg::CFG_INDEX_W'(2 * k)))
                    accel_off_reg[k] <= cfg_wdata;
                if (cfg_we && (cfg_index == isfb_pkg::REG_GYRO_OFF_0
                                           + isfb_pkg::CFG_INDEX_W'(2 * k)))
                    gyro_off_reg[k] <= cfg_wdata;
            end
            slot_reg       <= slot_next;
            frame_cnt_reg  <= frame_cnt_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // The holding stage captures the reading together with its frame position,
    // so the sequencing state can run ahead of the serializer.
    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            pend_ok_reg        <= s_tuser;
            pend_slot_reg      <= slot_reg;
            pend_header_reg    <= is_header;
            pend_last_reg      <= is_last;
            pend_size_reg      <= 8'(isfb_pkg::SIZE_BASE
                                     + isfb_pkg::SIZE_PER_SLOT * 32'(count_eff));
            pend_elapsed_reg   <= s_tdata[31:0];
            pend_frame_cnt_reg <= frame_cnt_reg;
            for (int a = 0; a < isfb_pkg::AXES; a++)
                pend_raw_reg[a] <= s_tdata[32 + AW*a +: AW];
        end
    end

    // Offset set of the slot the held reading came from.
    always_comb
    begin
        accel_sel = accel_off_reg[0];
        gyro_sel  = gyro_off_reg[0];
        for (int k = 1; k < SENSOR_SLOTS; k++)
        begin
            if (32'(pend_slot_reg) == k)
            begin
                accel_sel = accel_off_reg[k];
                gyro_sel  = gyro_off_reg[k];
            end
        end
    end

    // Six correction lanes, one per axis: accel x, y, z then gyro x, y, z.
    for (genvar a = 0; a < isfb_pkg::AXES; a++)
    begin : g_lane
        logic [isfb_pkg::OFF_REG_W-1:0] off_reg_sel;
        assign off_reg_sel = (a < 3) ? accel_sel : gyro_sel;

        isfb_axis_lane #(
            .FRAC_BITS (OFFSET_FRAC_BITS)
        ) u_lane (
            .read_ok   (pend_ok_reg),
            .raw       (pend_raw_reg[a]),
            .offset    (off_reg_sel[FW*(a % 3) +: FW]),
            .corrected (corrected[a])
        );
    end

    // Merge the lane results with the frame fields into one serializer load.
    always_comb
    begin
        item.header     = pend_header_reg;
        item.last       = pend_last_reg;
        item.size_byte  = pend_size_reg;
        item.elapsed_us = pend_elapsed_reg;
        item.frame_cnt  = pend_frame_cnt_reg;
        item.axis       = corrected;
    end

    isfb_serializer u_serializer (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (pend_valid_reg),
        .item       (item),
        .item_take  (item_take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

// ===== design/isfb_axis_lane.sv =====
module isfb_axis_lane #(
    parameter int FRAC_BITS = isfb_pkg::OFFSET_FRAC_BITS_DEF
) (
    input  logic                                  read_ok,
    input  logic signed [isfb_pkg::AXIS_W-1:0]    raw,
    input  logic signed [isfb_pkg::OFF_FIELD_W-1:0] offset,
    output logic        [isfb_pkg::AXIS_W-1:0]    corrected
);

    localparam int          DIFF_W  = isfb_pkg::OFF_FIELD_W + 1;
    localparam logic [DIFF_W-1:0] HALF    = DIFF_W'((1 << FRAC_BITS) >> 1);
    localparam logic [DIFF_W-1:0] POS_MAX = DIFF_W'(32767);
    localparam logic [DIFF_W-1:0] NEG_MAX = DIFF_W'(32768);

    logic signed [DIFF_W-1:0] raw_ext;
    logic signed [DIFF_W-1:0] off_ext;
    logic signed [DIFF_W-1:0] diff;
    logic                     neg;
    logic        [DIFF_W-1:0] mag;
    logic        [DIFF_W-1:0] quot;
    logic        [DIFF_W-1:0] sat;

    // Scale the raw count to the offset's fixed point, subtract, round the magnitude
    // half away from zero and clamp to the int16 range; a failed read gives zero.
    always_comb
    begin
        raw_ext = DIFF_W'(raw);
        off_ext = DIFF_W'(offset);
        diff    = (raw_ext <<< FRAC_BITS) - off_ext;
        neg     = diff[DIFF_W-1];
        mag     = neg ? DIFF_W'(-diff) : DIFF_W'(diff);
        quot    = (mag + HALF) >> FRAC_BITS;
        if (neg)
        begin
            sat = (quot > NEG_MAX) ? NEG_MAX : quot;
            sat = DIFF_W'(0) - sat;
        end
        else
        begin
            sat = (quot > POS_MAX) ? POS_MAX : quot;
        end
        corrected = read_ok ? sat[isfb_pkg::AXIS_W-1:0] : '0;
    end

endmodule

// ===== design/isfb_serializer.sv =====
module isfb_serializer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  isfb_pkg::isfb_item_t item,
    output logic                 item_take,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,
    output logic                 m_tlast
);

    logic                 active_reg, active_next;
    logic [4:0]           pos_reg, pos_next;
    logic [7:0]           xor_reg, xor_next;
    isfb_pkg::isfb_item_t item_reg;
    logic                 at_end;
    logic                 xfer;
    logic [4:0]           axis_off;
    logic [2:0]           axis_idx;
    logic [7:0]           byte_out;

    assign at_end    = item_reg.last ? (pos_reg == isfb_pkg::POS_CHECKSUM)
                                     : (pos_reg == isfb_pkg::POS_LAST_AXIS);
    assign xfer      = active_reg && m_tready;
    assign item_take = item_valid && (!active_reg || (xfer && at_end));
    assign axis_off  = pos_reg - isfb_pkg::POS_FIRST_AXIS;
    assign axis_idx  = axis_off[3:1];

    always_comb
    begin
        case (pos_reg) inside
            5'd0:      byte_out = isfb_pkg::SYNC_BYTE_0;
            5'd1:      byte_out = isfb_pkg::SYNC_BYTE_1;
            5'd2:      byte_out = isfb_pkg::FRAME_VERSION;
            5'd3:      byte_out = item_reg.size_byte;
            [5'd4:5'd7]:
                       byte_out = item_reg.elapsed_us[8*pos_reg[1:0] +: 8];
            [5'd8:5'd11]:
                       byte_out = item_reg.frame_cnt[8*pos_reg[1:0] +: 8];
            [isfb_pkg::POS_FIRST_AXIS:isfb_pkg::POS_LAST_AXIS]:
                       byte_out = item_reg.axis[axis_idx][8*axis_off[0] +: 8];
            isfb_pkg::POS_CHECKSUM:
                       byte_out = xor_reg;
            default:   byte_out = '0;
        endcase
    end

    always_comb
    begin
        active_next = active_reg;
        pos_next    = pos_reg;
        xor_next    = xor_reg;
        if (xfer)
        begin
            // The checksum restarts with the first sync byte of every frame.
            if (pos_reg == '0)
                xor_next = byte_out;
            else if (pos_reg == isfb_pkg::POS_CHECKSUM)
                xor_next = '0;
            else
                xor_next = xor_reg ^ byte_out;
            pos_next = pos_reg + 5'd1;
            if (at_end)
                active_next = 1'b0;
        end
        if (item_take)
        begin
            active_next = 1'b1;
            pos_next    = item.header ? 5'd0 : isfb_pkg::POS_FIRST_AXIS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            pos_reg    <= '0;
            xor_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            pos_reg    <= pos_next;
            xor_reg    <= xor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
            item_reg <= item;
    end

    assign m_tvalid = active_reg;
    assign m_tdata  = byte_out;
    assign m_tlast  = active_reg && (pos_reg == isfb_pkg::POS_CHECKSUM);

endmodule
